/* sv/pmws_pkg.sv */
// package for the paged mmu with swap
// holds sizes, status, request and table field codes and the memory request types; no dependencies
`default_nettype none
package pmws_pkg;
  localparam int NumFrames  = 4;
  localparam int FrameBytes = 16;
  localparam int NumProcs   = 4;
  localparam int PagesPerProc = 4;
  localparam int MemBytes   = NumFrames * FrameBytes;
  localparam int SlotBytes  = (PagesPerProc + 1) * FrameBytes;
  localparam int StoreBytes = NumProcs * SlotBytes;
  localparam int FrW  = $clog2(NumFrames);
  localparam int OffW = $clog2(FrameBytes);
  localparam int MaW  = $clog2(MemBytes);
  localparam int SaW  = $clog2(StoreBytes);
  localparam int PrW  = 2;
  localparam int VpW  = $clog2(PagesPerProc);
  localparam int LocW = 3;
  localparam logic [LocW-1:0] TableDisk = LocW'(NumFrames);
  localparam logic [LocW-1:0] TableNone = LocW'(NumFrames + 1);

  localparam logic [1:0] ReqMap    = 2'd0;
  localparam logic [1:0] ReqLoad   = 2'd1;
  localparam logic [1:0] ReqStore  = 2'd2;
  localparam logic [1:0] ReqUnused = 2'd3;

  localparam logic [2:0] StMapped    = 3'd0;
  localparam logic [2:0] StPermUpd   = 3'd1;
  localparam logic [2:0] StPermSame  = 3'd2;
  localparam logic [2:0] StLoaded    = 3'd3;
  localparam logic [2:0] StStored    = 3'd4;
  localparam logic [2:0] StUnalloc   = 3'd5;
  localparam logic [2:0] StNotWrite  = 3'd6;

  localparam logic [1:0] FValid = 2'd0;
  localparam logic [1:0] FFrame = 2'd1;
  localparam logic [1:0] FWrite = 2'd2;
  localparam logic [1:0] FPres  = 2'd3;

  typedef struct packed {
    logic          we;
    logic [MaW-1:0] addr;
    logic [7:0]    wdata;
  } mem_req_t;

  typedef struct packed {
    logic          we;
    logic [SaW-1:0] addr;
    logic [7:0]    wdata;
  } sto_req_t;
endpackage
`default_nettype wire

/* sv/pmws_ram.sv */
// generic single port ram with registered read
// no dependencies
`default_nettype none
module pmws_ram #(
  parameter int Depth = 64,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [7:0]       wdata_i,
  output logic      [7:0]       rdata_o
);
  logic [7:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule
`default_nettype wire

/* sv/pmws_ctrl.sv */
// sequencer for map, load and store with swapping
// depends on pmws_pkg; drives physical memory and backing store rams
`default_nettype none
module pmws_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire logic [1:0] req_type_i,
  input  wire logic [1:0] process_id_i,
  input  wire logic [5:0] virtual_address_i,
  input  wire logic writable_flag_i,
  input  wire logic [7:0] write_data_i,
  output logic busy_o,
  output logic done_o,
  output logic [2:0] status_o,
  output logic [7:0] read_data_o,
  output logic [1:0] frame_used_o,
  output logic [2:0] evictions_o,
  output pmws_pkg::mem_req_t mem_o,
  input  wire logic [7:0] mem_rdata_i,
  output pmws_pkg::sto_req_t sto_o,
  input  wire logic [7:0] sto_rdata_i,
  output logic [pmws_pkg::NumFrames-1:0] mem_clr_o
);
  localparam int FrW = pmws_pkg::FrW;
  localparam int OffW = pmws_pkg::OffW;
  localparam int SaW = pmws_pkg::SaW;
  localparam int MaW = pmws_pkg::MaW;
  localparam int LocW = pmws_pkg::LocW;
  localparam int NumF = pmws_pkg::NumFrames;
  localparam int pmws_procs = pmws_pkg::NumProcs;

  typedef enum logic [4:0] {
    S_IDLE, S_DISP, S_GRAB, S_SKIP, S_EV_PTR, S_EV_COPY, S_EV_WAIT, S_EV_FIX,
    S_EV_DONE, S_AFTER, S_TBL_RD, S_TBL_WR, S_MAIN, S_RD_V, S_RD_V2, S_RD_W,
    S_RD_W2, S_RD_P, S_RD_P2, S_MAP_WR, S_PG_RD, S_PG_WR, S_PG_FIX, S_RD_F,
    S_RD_F2, S_ACCESS, S_ACC2, S_DONE
  } state_e;

  typedef enum logic [1:0] {G_FETCH, G_CREATE, G_MAP, G_SWAPIN} goal_e;

  state_e state_q;
  goal_e goal_q;
  logic [1:0] type_q, proc_q;
  logic [5:0] va_q;
  logic rw_q;
  logic [7:0] wd_q;
  logic [2:0] status_q, ev_q;
  logic [7:0] rd_q;
  logic [1:0] used_q;
  logic skip_q;
  logic [FrW-1:0] ptr_q, f_q;
  logic [OffW:0] cnt_q;
  logic valid_q, wr_q;
  logic [NumF-1:0] taken_q, htab_q;
  logic [1:0] owner_q [NumF];
  logic [5:0] fva_q [NumF];
  logic [LocW-1:0] loc_q [pmws_procs];

  logic [pmws_pkg::VpW-1:0] vpn;
  logic [LocW-1:0] tloc;
  logic [FrW-1:0] tfr;
  logic free_found;
  logic [FrW-1:0] free_idx;
  logic [FrW-1:0] ptr_nx;
  logic [1:0] ev_own;
  logic [pmws_pkg::VpW-1:0] ev_vpn;

  assign vpn = va_q[OffW +: pmws_pkg::VpW];
  assign tloc = loc_q[proc_q];
  assign tfr = tloc[FrW-1:0];
  assign ptr_nx = ptr_q + FrW'(1);
  assign ev_own = owner_q[ptr_q];
  assign ev_vpn = fva_q[ptr_q][OffW +: pmws_pkg::VpW];

  always_comb begin
    free_found = 1'b0;
    free_idx = '0;
    for (int i = NumF - 1; i >= 0; i--) begin
      if (!taken_q[i]) begin
        free_found = 1'b1;
        free_idx = FrW'(i);
      end
    end
  end

  function automatic logic [MaW-1:0] ent(input logic [FrW-1:0] fr,
      input logic [pmws_pkg::VpW-1:0] vp, input logic [1:0] fld);
    logic [OffW-1:0] o;
    o = OffW'({vp, fld});
    return {fr, o};
  endfunction

  function automatic logic [SaW-1:0] sbase(input logic [1:0] p,
      input logic [pmws_pkg::VpW:0] area);
    return SaW'(p * pmws_pkg::SlotBytes + area * pmws_pkg::FrameBytes);
  endfunction

  assign busy_o = (state_q != S_IDLE);

  always_comb begin
    mem_o = '0;
    sto_o = '0;
    mem_clr_o = '0;
    case (state_q)
      S_EV_COPY: mem_o.addr = {ptr_q, cnt_q[OffW-1:0]};
      S_EV_WAIT: begin
        mem_o.addr = {ptr_q, cnt_q[OffW-1:0]};
        sto_o.we = 1'b1;
        sto_o.wdata = mem_rdata_i;
        sto_o.addr = (htab_q[ptr_q] ? sbase(ev_own, '0)
                      : sbase(ev_own, {1'b0, ev_vpn} + 1'b1)) + SaW'(cnt_q - 1'b1);
      end
      S_EV_FIX: begin
        if (!htab_q[ptr_q]) begin
          if (loc_q[ev_own] < LocW'(NumF)) begin
            mem_o.we = 1'b1;
            mem_o.addr = ent(loc_q[ev_own][FrW-1:0], ev_vpn, pmws_pkg::FPres);
          end else if (loc_q[ev_own] == pmws_pkg::TableDisk) begin
            sto_o.we = 1'b1;
            sto_o.addr = sbase(ev_own, '0) + SaW'({ev_vpn, pmws_pkg::FPres});
          end
        end
        mem_clr_o[ptr_q] = 1'b1;
      end
      S_TBL_RD: sto_o.addr = sbase(proc_q, '0) + SaW'(cnt_q[OffW-1:0]);
      S_TBL_WR: begin
        sto_o.addr = sbase(proc_q, '0) + SaW'(cnt_q[OffW-1:0]);
        mem_o.we = 1'b1;
        mem_o.addr = {f_q, OffW'(cnt_q - 1'b1)};
        mem_o.wdata = sto_rdata_i;
      end
      S_PG_RD: sto_o.addr = sbase(proc_q, {1'b0, vpn} + 1'b1) + SaW'(cnt_q[OffW-1:0]);
      S_PG_WR: begin
        sto_o.addr = sbase(proc_q, {1'b0, vpn} + 1'b1) + SaW'(cnt_q[OffW-1:0]);
        mem_o.we = 1'b1;
        mem_o.addr = {f_q, OffW'(cnt_q - 1'b1)};
        mem_o.wdata = sto_rdata_i;
      end
      S_PG_FIX: begin
        mem_o.we = 1'b1;
        mem_o.addr = ent(tfr, vpn, cnt_q[0] ? pmws_pkg::FFrame : pmws_pkg::FPres);
        mem_o.wdata = cnt_q[0] ? 8'(f_q) : 8'd1;
      end
      S_RD_V: mem_o.addr = ent(tfr, vpn, pmws_pkg::FValid);
      S_RD_W: mem_o.addr = ent(tfr, vpn, pmws_pkg::FWrite);
      S_RD_P: mem_o.addr = ent(tfr, vpn, pmws_pkg::FPres);
      S_RD_F: mem_o.addr = ent(tfr, vpn, pmws_pkg::FFrame);
      S_MAP_WR: begin
        mem_o.we = 1'b1;
        case (cnt_q[1:0])
          2'd0: begin
            mem_o.addr = ent(tfr, vpn, pmws_pkg::FWrite);
            mem_o.wdata = 8'(rw_q);
          end
          2'd1: begin
            mem_o.addr = ent(tfr, vpn, pmws_pkg::FPres);
            mem_o.wdata = 8'd1;
          end
          2'd2: begin
            mem_o.addr = ent(tfr, vpn, pmws_pkg::FFrame);
            mem_o.wdata = 8'(f_q);
          end
          default: begin
            mem_o.addr = ent(tfr, vpn, pmws_pkg::FValid);
            mem_o.wdata = 8'd1;
          end
        endcase
      end
      S_ACCESS: begin
        if (type_q == pmws_pkg::ReqMap) begin
          mem_o.we = (wr_q != rw_q);
          mem_o.addr = ent(tfr, vpn, pmws_pkg::FWrite);
          mem_o.wdata = 8'(rw_q);
        end else begin
          mem_o.we = (type_q == pmws_pkg::ReqStore);
          mem_o.addr = {used_q[FrW-1:0], va_q[OffW-1:0]};
          mem_o.wdata = wd_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      goal_q <= G_FETCH;
      taken_q <= '0;
      htab_q <= '0;
      ptr_q <= '0;
      done_o <= 1'b0;
      for (int i = 0; i < NumF; i++) begin
        owner_q[i] <= '0;
        fva_q[i] <= '0;
      end
      for (int i = 0; i < pmws_procs; i++) loc_q[i] <= pmws_pkg::TableNone;
      status_q <= '0; rd_q <= '0; used_q <= '0; ev_q <= '0;
      type_q <= '0; proc_q <= '0; va_q <= '0; rw_q <= '0; wd_q <= '0;
      skip_q <= '0; f_q <= '0; cnt_q <= '0; valid_q <= '0; wr_q <= '0;
    end else begin
      done_o <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            type_q <= req_type_i; proc_q <= process_id_i; va_q <= virtual_address_i;
            rw_q <= writable_flag_i; wd_q <= write_data_i;
            status_q <= pmws_pkg::StUnalloc; rd_q <= '0; used_q <= '0; ev_q <= '0;
            state_q <= S_DISP;
          end
        end
        S_DISP: begin
          if (type_q == pmws_pkg::ReqUnused) state_q <= S_DONE;
          else if (type_q == pmws_pkg::ReqMap && tloc == pmws_pkg::TableNone) begin
            goal_q <= G_CREATE; skip_q <= 1'b0; state_q <= S_GRAB;
          end else if (tloc == pmws_pkg::TableDisk) begin
            goal_q <= G_FETCH; skip_q <= 1'b0; state_q <= S_GRAB;
          end else if (tloc < LocW'(NumF)) state_q <= S_RD_V;
          else state_q <= S_DONE;
        end
        S_GRAB: begin
          if (free_found) begin
            f_q <= free_idx; state_q <= S_AFTER;
          end else begin
            ptr_q <= ptr_nx; state_q <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (skip_q && owner_q[ptr_q] == proc_q && htab_q[ptr_q]) ptr_q <= ptr_nx;
          cnt_q <= '0;
          state_q <= S_EV_COPY;
        end
        S_EV_COPY: begin
          cnt_q <= cnt_q + 1'b1; state_q <= S_EV_WAIT;
        end
        S_EV_WAIT: begin
          if (cnt_q == (OffW+1)'(pmws_pkg::FrameBytes)) state_q <= S_EV_FIX;
          else cnt_q <= cnt_q + 1'b1;
        end
        S_EV_FIX: begin
          if (htab_q[ptr_q]) begin
            loc_q[ev_own] <= pmws_pkg::TableDisk;
            htab_q[ptr_q] <= 1'b0;
          end
          taken_q[ptr_q] <= 1'b0;
          if (ev_q != 3'd7) ev_q <= ev_q + 1'b1;
          f_q <= ptr_q;
          state_q <= S_AFTER;
        end
        S_AFTER: begin
          cnt_q <= '0;
          case (goal_q)
            G_FETCH: state_q <= S_TBL_RD;
            G_CREATE: begin
              taken_q[f_q] <= 1'b1; htab_q[f_q] <= 1'b1; owner_q[f_q] <= proc_q;
              fva_q[f_q] <= va_q; loc_q[proc_q] <= LocW'(f_q);
              state_q <= S_RD_V;
            end
            G_MAP: begin
              taken_q[f_q] <= 1'b1; htab_q[f_q] <= 1'b0; owner_q[f_q] <= proc_q;
              fva_q[f_q] <= va_q; state_q <= S_MAP_WR;
            end
            default: state_q <= S_PG_RD;
          endcase
        end
        S_TBL_RD: begin
          cnt_q <= cnt_q + 1'b1; state_q <= S_TBL_WR;
        end
        S_TBL_WR: begin
          if (cnt_q == (OffW+1)'(pmws_pkg::FrameBytes)) begin
            taken_q[f_q] <= 1'b1; htab_q[f_q] <= 1'b1; owner_q[f_q] <= proc_q;
            loc_q[proc_q] <= LocW'(f_q);
            state_q <= S_RD_V;
          end else cnt_q <= cnt_q + 1'b1;
        end
        S_RD_V: state_q <= S_RD_V2;
        S_RD_V2: begin
          valid_q <= (mem_rdata_i == 8'd1); state_q <= S_RD_W;
        end
        S_RD_W: state_q <= S_RD_W2;
        S_RD_W2: begin
          wr_q <= (mem_rdata_i == 8'd1);
          if (type_q == pmws_pkg::ReqMap && !valid_q) begin
            goal_q <= G_MAP; skip_q <= 1'b1; state_q <= S_GRAB;
          end else if (valid_q && (type_q != pmws_pkg::ReqStore || mem_rdata_i == 8'd1))
            state_q <= S_RD_P;
          else begin
            if (valid_q) status_q <= pmws_pkg::StNotWrite;
            state_q <= S_DONE;
          end
        end
        S_MAP_WR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[1:0] == 2'd3) begin
            status_q <= pmws_pkg::StMapped; used_q <= 2'(f_q); state_q <= S_DONE;
          end
        end
        S_RD_P: state_q <= S_RD_P2;
        S_RD_P2: begin
          if (mem_rdata_i != 8'd1) begin
            goal_q <= G_SWAPIN; skip_q <= 1'b1; state_q <= S_GRAB;
          end else state_q <= S_RD_F;
        end
        S_PG_RD: begin
          cnt_q <= cnt_q + 1'b1; state_q <= S_PG_WR;
        end
        S_PG_WR: begin
          if (cnt_q == (OffW+1)'(pmws_pkg::FrameBytes)) begin
            taken_q[f_q] <= 1'b1; htab_q[f_q] <= 1'b0; owner_q[f_q] <= proc_q;
            fva_q[f_q] <= va_q; cnt_q <= '0; state_q <= S_PG_FIX;
          end else cnt_q <= cnt_q + 1'b1;
        end
        S_PG_FIX: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q[0]) state_q <= S_RD_F;
        end
        S_RD_F: state_q <= S_RD_F2;
        S_RD_F2: begin
          used_q <= 2'(mem_rdata_i[FrW-1:0]); state_q <= S_ACCESS;
        end
        S_ACCESS: begin
          if (type_q == pmws_pkg::ReqMap) begin
            status_q <= (wr_q == rw_q) ? pmws_pkg::StPermSame : pmws_pkg::StPermUpd;
            state_q <= S_DONE;
          end else if (type_q == pmws_pkg::ReqLoad) state_q <= S_ACC2;
          else begin
            status_q <= pmws_pkg::StStored; state_q <= S_DONE;
          end
        end
        S_ACC2: begin
          rd_q <= mem_rdata_i; status_q <= pmws_pkg::StLoaded; state_q <= S_DONE;
        end
        S_DONE: begin
          done_o <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign status_o = status_q;
  assign read_data_o = rd_q;
  assign frame_used_o = used_q;
  assign evictions_o = ev_q;
endmodule
`default_nettype wire

/* sv/pmws_pmem.sv */
// physical memory with per-frame clear through valid bits
// depends on pmws_pkg
`default_nettype none
module pmws_pmem (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  pmws_pkg::mem_req_t req_i,
  input  wire logic [pmws_pkg::NumFrames-1:0] clr_i,
  output logic [7:0] rdata_o
);
  localparam int Bytes = pmws_pkg::MemBytes;
  logic [7:0] mem_q [Bytes];
  logic [Bytes-1:0] vld_q;
  logic [7:0] raw_q;
  logic rv_q;
  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.addr] <= req_i.wdata;
    raw_q <= mem_q[req_i.addr];
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      rv_q <= 1'b0;
    end else begin
      rv_q <= vld_q[req_i.addr];
      for (int f = 0; f < pmws_pkg::NumFrames; f++) begin
        if (clr_i[f]) vld_q[f*pmws_pkg::FrameBytes +: pmws_pkg::FrameBytes] <= '0;
      end
      if (req_i.we) vld_q[req_i.addr] <= 1'b1;
    end
  end
  assign rdata_o = rv_q ? raw_q : 8'd0;
endmodule
`default_nettype wire

/* sv/paged_mmu_with_swap.sv */
// paged mmu with round-robin swap to a backing store
// a transaction may fetch its table and page in its data, each evicting a frame first;
// frames move as 16-byte copies, a byte a cycle
// throughput: one transaction at a time; the next is taken once the result is accepted
// reset: control and tables clear at once; memory reads zero via per-byte valid bits
// depends on pmws_pkg, pmws_ctrl, pmws_pmem, pmws_ram
`default_nettype none
module paged_mmu_with_swap (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire logic [1:0] req_type_i,
  input  wire logic [1:0] process_id_i,
  input  wire logic [5:0] virtual_address_i,
  input  wire logic writable_flag_i,
  input  wire logic [7:0] write_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output logic [2:0] status_o,
  output logic [7:0] read_data_o,
  output logic [1:0] frame_used_o,
  output logic [2:0] evictions_o
);
  pmws_pkg::mem_req_t mem_req;
  pmws_pkg::sto_req_t sto_req;
  logic [7:0] mem_rd, sto_rd;
  logic [pmws_pkg::NumFrames-1:0] clr;
  logic busy, done;
  logic [2:0] st;
  logic [7:0] rd;
  logic [1:0] fu;
  logic [2:0] ev;
  logic start;

  assign in_stall_o = busy || done || out_valid_o;
  assign start = in_valid_i && !in_stall_o;

  pmws_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start),
    .req_type_i, .process_id_i, .virtual_address_i, .writable_flag_i, .write_data_i,
    .busy_o(busy), .done_o(done),
    .status_o(st), .read_data_o(rd), .frame_used_o(fu), .evictions_o(ev),
    .mem_o(mem_req), .mem_rdata_i(mem_rd), .sto_o(sto_req), .sto_rdata_i(sto_rd),
    .mem_clr_o(clr)
  );

  pmws_pmem u_pmem (.clk_i, .rst_ni, .req_i(mem_req), .clr_i(clr), .rdata_o(mem_rd));

  pmws_ram #(.Depth(pmws_pkg::StoreBytes)) u_store (
    .clk_i, .we_i(sto_req.we), .addr_i(sto_req.addr), .wdata_i(sto_req.wdata),
    .rdata_o(sto_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      status_o <= '0; read_data_o <= '0; frame_used_o <= '0; evictions_o <= '0;
    end else begin
      if (done) begin
        out_valid_o <= 1'b1;
        status_o <= st; read_data_o <= rd; frame_used_o <= fu; evictions_o <= ev;
      end else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> busy) else $error("accepted transaction did not start work");
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done |=> out_valid_o) else $error("result lost");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 3'd7) else $error("bad status");
`endif
endmodule
`default_nettype wire

/* test/paged_mmu_with_swap_tb.sv */
// testbench for paged_mmu_with_swap: directed and random map, load and store transactions
// a built-in page table and swap predictor checks every result; depends on pmws_pkg
`timescale 1ns / 100ps
module paged_mmu_with_swap_tb;
  localparam int NumFrames = pmws_pkg::NumFrames;
  localparam int FrameBytes = pmws_pkg::FrameBytes;
  localparam int NumProcs = pmws_pkg::NumProcs;
  localparam int PagesPerProc = pmws_pkg::PagesPerProc;
  localparam int MemBytes = pmws_pkg::MemBytes;
  localparam int SlotBytes = pmws_pkg::SlotBytes;
  localparam int StoreBytes = pmws_pkg::StoreBytes;
  localparam logic [2:0] TableDisk = pmws_pkg::TableDisk;
  localparam logic [2:0] TableNone = pmws_pkg::TableNone;
  localparam logic [1:0] ReqMap = pmws_pkg::ReqMap;
  localparam logic [1:0] ReqLoad = pmws_pkg::ReqLoad;
  localparam logic [1:0] ReqStore = pmws_pkg::ReqStore;
  localparam logic [1:0] ReqUnused = pmws_pkg::ReqUnused;
  localparam logic [2:0] StMapped = pmws_pkg::StMapped;
  localparam logic [2:0] StPermUpd = pmws_pkg::StPermUpd;
  localparam logic [2:0] StPermSame = pmws_pkg::StPermSame;
  localparam logic [2:0] StLoaded = pmws_pkg::StLoaded;
  localparam logic [2:0] StStored = pmws_pkg::StStored;
  localparam logic [2:0] StUnalloc = pmws_pkg::StUnalloc;
  localparam logic [2:0] StNotWrite = pmws_pkg::StNotWrite;
  localparam logic [1:0] FValid = pmws_pkg::FValid;
  localparam logic [1:0] FFrame = pmws_pkg::FFrame;
  localparam logic [1:0] FWrite = pmws_pkg::FWrite;
  localparam logic [1:0] FPres = pmws_pkg::FPres;

  typedef struct {
    logic [1:0] req;
    logic [1:0] pid;
    logic [5:0] va;
    logic       wr;
    logic [7:0] data;
  } mmu_req_t;

  typedef struct {
    logic [2:0] status;
    logic [7:0] rdata;
    logic [1:0] frame;
    logic [2:0] evicts;
  } mmu_rsp_t;

  localparam int CycleLimit = 2000000;
  localparam int RandomItems = 1400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] req_type_i = '0;
  logic [1:0] process_id_i = '0;
  logic [5:0] virtual_address_i = '0;
  logic writable_flag_i = 1'b0;
  logic [7:0] write_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] status_o;
  logic [7:0] read_data_o;
  logic [1:0] frame_used_o;
  logic [2:0] evictions_o;

  paged_mmu_with_swap u_dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state
  logic [7:0] pmem [MemBytes];
  logic [7:0] disk [StoreBytes];
  bit taken [NumFrames];
  bit holds_tbl [NumFrames];
  int owner [NumFrames];
  int fr_va [NumFrames];
  int tbl_loc [NumProcs];
  int evict_ptr;
  int evict_cnt;

  mmu_req_t pending_reqs[$];
  mmu_rsp_t expected_rsps[$];
  int total_reqs = 0;
  int sent = 0;
  int received = 0;
  int errors = 0;
  int cycles = 0;
  int total_evicts = 0;
  bit stim_done = 1'b0;

  function automatic int vpage(int va);
    return (va / FrameBytes) % PagesPerProc;
  endfunction

  function automatic int entry_addr(int fr, int vpn, int fld);
    return (fr % NumFrames) * FrameBytes + (4 * vpn + fld) % FrameBytes;
  endfunction

  function automatic void swap_out_frame();
    int f, o, base, vpn, loc;
    f = evict_ptr;
    o = owner[f];
    base = f * FrameBytes;
    if (holds_tbl[f]) begin
      for (int i = 0; i < FrameBytes; i++) disk[o * SlotBytes + i] = pmem[base + i];
      tbl_loc[o] = TableDisk;
      holds_tbl[f] = 1'b0;
    end else begin
      vpn = vpage(fr_va[f]);
      loc = tbl_loc[o];
      for (int i = 0; i < FrameBytes; i++)
        disk[o * SlotBytes + (vpn + 1) * FrameBytes + i] = pmem[base + i];
      if (loc < NumFrames) pmem[entry_addr(loc, vpn, FPres)] = 8'd0;
      else if (loc == TableDisk) disk[o * SlotBytes + (4 * vpn + FPres) % FrameBytes] = 8'd0;
    end
    for (int i = 0; i < FrameBytes; i++) pmem[base + i] = 8'd0;
    taken[f] = 1'b0;
    if (evict_cnt < 7) evict_cnt++;
  endfunction

  function automatic int claim_frame(int pid, bit skip_own);
    for (int i = 0; i < NumFrames; i++) if (!taken[i]) return i;
    evict_ptr = (evict_ptr + 1) % NumFrames;
    if (skip_own && owner[evict_ptr] == pid && holds_tbl[evict_ptr])
      evict_ptr = (evict_ptr + 1) % NumFrames;
    swap_out_frame();
    return evict_ptr;
  endfunction

  function automatic void place_table(int pid, int f);
    taken[f] = 1'b1;
    holds_tbl[f] = 1'b1;
    owner[f] = pid;
    tbl_loc[pid] = f;
  endfunction

  function automatic mmu_rsp_t predict_access(mmu_req_t r);
    mmu_rsp_t rsp;
    int pid, va, vpn, t, f, ev, ef, ew, ep, addr;
    bit ok;
    pid = r.pid;
    va = r.va;
    vpn = vpage(va);
    rsp.status = StUnalloc;
    rsp.rdata = '0;
    rsp.frame = '0;
    evict_cnt = 0;
    if (r.req <= ReqStore) begin
      if (r.req == ReqMap && tbl_loc[pid] == TableNone) begin
        f = claim_frame(pid, 1'b0);
        for (int i = 0; i < FrameBytes; i++) pmem[f * FrameBytes + i] = 8'd0;
        place_table(pid, f);
        fr_va[f] = va;
      end
      if (tbl_loc[pid] == TableDisk) begin
        f = claim_frame(pid, 1'b0);
        for (int i = 0; i < FrameBytes; i++) pmem[f * FrameBytes + i] = disk[pid * SlotBytes + i];
        place_table(pid, f);
      end
      t = tbl_loc[pid];
      if (t < NumFrames) begin
        ev = entry_addr(t, vpn, FValid);
        ef = entry_addr(t, vpn, FFrame);
        ew = entry_addr(t, vpn, FWrite);
        ep = entry_addr(t, vpn, FPres);
        ok = pmem[ev] == 8'd1;
        if (r.req == ReqMap && !ok) begin
          f = claim_frame(pid, 1'b1);
          taken[f] = 1'b1;
          holds_tbl[f] = 1'b0;
          pmem[ew] = r.wr;
          pmem[ep] = 8'd1;
          pmem[ef] = f;
          pmem[ev] = 8'd1;
          owner[f] = pid;
          fr_va[f] = va;
          rsp.status = StMapped;
          rsp.frame = f;
        end else if (ok && (r.req != ReqStore || pmem[ew] == 8'd1)) begin
          if (pmem[ep] != 8'd1) begin
            f = claim_frame(pid, 1'b1);
            t = tbl_loc[pid];
            for (int i = 0; i < FrameBytes; i++)
              pmem[f * FrameBytes + i] = disk[pid * SlotBytes + (vpn + 1) * FrameBytes + i];
            taken[f] = 1'b1;
            holds_tbl[f] = 1'b0;
            owner[f] = pid;
            fr_va[f] = va;
            if (t < NumFrames) begin
              pmem[entry_addr(t, vpn, FPres)] = 8'd1;
              pmem[entry_addr(t, vpn, FFrame)] = f;
            end
          end
          rsp.frame = pmem[ef] % NumFrames;
          addr = rsp.frame * FrameBytes + va % FrameBytes;
          if (r.req == ReqMap) begin
            if (pmem[ew] == {7'd0, r.wr}) rsp.status = StPermSame;
            else begin
              pmem[ew] = r.wr;
              rsp.status = StPermUpd;
            end
          end else if (r.req == ReqLoad) begin
            rsp.rdata = pmem[addr];
            rsp.status = StLoaded;
          end else begin
            pmem[addr] = r.data;
            rsp.status = StStored;
          end
        end else if (ok) begin
          rsp.status = StNotWrite;
        end
      end
    end
    rsp.evicts = evict_cnt;
    total_evicts += evict_cnt;
    return rsp;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch on transaction %0d: %s got %0d expected %0d", received, what, got, want);
    errors++;
  endtask

  function automatic void add_req(int req, int pid, int va, int wr, int data);
    mmu_req_t r;
    r.req = req;
    r.pid = pid;
    r.va = va;
    r.wr = wr;
    r.data = data;
    pending_reqs.push_back(r);
    total_reqs++;
  endfunction

  // idle percentages per phase of the run
  function automatic int sender_idle();
    case ((sent * 4) / (total_reqs + 1))
      1: return 74;
      3: return 9;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall();
    case ((sent * 4) / (total_reqs + 1))
      2: return 74;
      3: return 9;
      default: return 0;
    endcase
  endfunction

  // driver
  always @(posedge clk_i) begin
    mmu_req_t r;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        r.req = req_type_i;
        r.pid = process_id_i;
        r.va = virtual_address_i;
        r.wr = writable_flag_i;
        r.data = write_data_i;
        expected_rsps.push_back(predict_access(r));
        sent++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= sender_idle()) begin
          r = pending_reqs.pop_front();
          in_valid_i <= 1'b1;
          req_type_i <= r.req;
          process_id_i <= r.pid;
          virtual_address_i <= r.va;
          writable_flag_i <= r.wr;
          write_data_i <= r.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    mmu_rsp_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_rsps.size() == 0) begin
          $display("unexpected result transaction, status %0d", status_o);
          errors++;
        end else begin
          e = expected_rsps.pop_front();
          if (status_o !== e.status) report_mismatch("status", status_o, e.status);
          if (read_data_o !== e.rdata) report_mismatch("read_data", read_data_o, e.rdata);
          if (frame_used_o !== e.frame) report_mismatch("frame_used", frame_used_o, e.frame);
          if (evictions_o !== e.evicts) report_mismatch("evictions", evictions_o, e.evicts);
        end
        received++;
      end
      out_stall_i <= $urandom_range(99) < receiver_stall();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, expected_rsps.size());
      $display("FAIL paged_mmu_with_swap");
      $finish;
    end
  end

  initial begin
    int kind, pid;
    for (int i = 0; i < MemBytes; i++) pmem[i] = 8'd0;
    for (int i = 0; i < StoreBytes; i++) disk[i] = 8'd0;
    for (int i = 0; i < NumFrames; i++) begin
      taken[i] = 1'b0;
      holds_tbl[i] = 1'b0;
      owner[i] = 0;
      fr_va[i] = 0;
    end
    for (int i = 0; i < NumProcs; i++) tbl_loc[i] = TableNone;
    evict_ptr = 0;

    // directed: missing table, unused type, permissions, extremes, evictions
    add_req(ReqLoad, 1, 0, 0, 0);
    add_req(ReqStore, 2, 63, 1, 255);
    add_req(ReqUnused, 0, 0, 0, 0);
    add_req(ReqMap, 0, 0, 1, 0);
    add_req(ReqStore, 0, 0, 0, 255);
    add_req(ReqStore, 0, 15, 0, 0);
    add_req(ReqLoad, 0, 0, 0, 0);
    add_req(ReqLoad, 0, 63, 0, 0);
    add_req(ReqMap, 0, 0, 0, 0);
    add_req(ReqMap, 0, 0, 0, 0);
    add_req(ReqStore, 0, 5, 0, 8'hA5);
    add_req(ReqMap, 0, 63, 1, 0);
    add_req(ReqMap, 1, 16, 1, 0);
    add_req(ReqMap, 2, 32, 1, 0);
    add_req(ReqStore, 2, 47, 0, 8'h5A);
    add_req(ReqMap, 3, 48, 1, 0);
    add_req(ReqLoad, 0, 0, 0, 0);
    add_req(ReqLoad, 0, 15, 0, 0);
    add_req(ReqLoad, 2, 47, 0, 0);
    add_req(ReqMap, 0, 0, 1, 0);
    add_req(ReqStore, 0, 0, 1, 8'h3C);
    add_req(ReqLoad, 1, 16, 0, 0);
    add_req(ReqUnused, 3, 63, 1, 255);

    // random: mostly loads and stores with some maps across all processes, some noise
    for (int n = 0; n < RandomItems; n++) begin
      kind = $urandom_range(99);
      pid = $urandom_range(NumProcs - 1);
      if (kind < 25) add_req(ReqMap, pid, $urandom_range(63), $urandom_range(1), $urandom_range(255));
      else if (kind < 60) add_req(ReqLoad, pid, $urandom_range(63), $urandom_range(1), $urandom_range(255));
      else if (kind < 95) add_req(ReqStore, pid, $urandom_range(63), $urandom_range(1), $urandom_range(255));
      else add_req(ReqUnused, pid, $urandom_range(63), $urandom_range(1), $urandom_range(255));
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_reqs.size() == 0 && !in_valid_i && expected_rsps.size() == 0);
    repeat (300) @(posedge clk_i);
    $display("covered %0d transactions with %0d results and %0d frame evictions",
             sent, received, total_evicts);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("PASS paged_mmu_with_swap");
    end else begin
      $display("FAIL paged_mmu_with_swap");
    end
    $finish;
  end
endmodule
